@@ rtl/core/multichannel_fir_smoother_defines.svh @@
// Assertion macros for the multichannel FIR smoother.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef MULTICHANNEL_FIR_SMOOTHER_DEFINES_SVH
`define MULTICHANNEL_FIR_SMOOTHER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MFS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define MFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/mfs_pkg.sv @@
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared widths, constants and controller/datapath handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package mfs_pkg;

	// Field widths
	localparam int CH_W       = 3;
	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int FRAC_BITS  = 15;

	// Coefficient register file
	localparam int NUM_COEFS  = 6;
	localparam int COEF_IDX_W = $clog2(NUM_COEFS);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = COEF_W;

	// Register index of the last coefficient; register i holds coef_i
	localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST = CFG_IDX_W'(NUM_COEFS - 1);

	// Arithmetic widths: full product, and the sum of all weighted taps
	localparam int PROD_W = SAMPLE_W + COEF_W;
	localparam int ACC_W  = PROD_W + $clog2(NUM_COEFS) + 1;

	// Default geometry
	localparam int DEF_TAPS     = 6;
	localparam int DEF_CHANNELS = 6;

	// Controller to datapath commands
	typedef struct packed {
		logic start;   // word accepted: latch, write history, clear accumulator
		logic issue;   // read one tap and advance the tap counter
		logic fin;     // load the result into the output register
	} mfs_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic ch_ok;     // incoming channel is in range
		logic last_tap;  // current tap is the oldest one
		logic out_free;  // output register can take a new word
	} mfs_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/mfs_in_if.sv @@
// ----------------------------------------------------------------------------
// mfs_in_if
// Sample channel: valid/ready handshake with channel number and sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfs_in_if import mfs_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [CH_W-1:0]            channel;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output channel, output sample, input ready);
	modport sink   (input valid, input channel, input sample, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mfs_out_if.sv @@
// ----------------------------------------------------------------------------
// mfs_out_if
// Result channel: valid/ready handshake with echoed channel and filtered value.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfs_out_if import mfs_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [CH_W-1:0]            out_channel;
	logic signed [SAMPLE_W-1:0] filtered;

	modport source (output valid, output out_channel, output filtered, input ready);
	modport sink   (input valid, input out_channel, input filtered, output ready);
endinterface

`default_nettype wire

@@ rtl/core/multichannel_fir_smoother.sv @@
// ----------------------------------------------------------------------------
// multichannel_fir_smoother
// FIR smoother over TAPS samples for up to CHANNELS axes with shared weights.
// Input word (din): channel and signed sample; output word (dout): the echoed
// channel and the filtered value, one output word per input word, in order.
// Weights coef_0..coef_5 are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce. coef_i weights the i-th newest sample of the channel.
// After an accept the single shared MAC walks the taps one per cycle through
// the single-port read of the history memory, the multiply pipe drains and
// the result goes to the output register before the next word is taken. A
// word with an out-of-range channel leaves the history alone and returns
// zero. Reset clears the weights, write positions and fill counts; history
// entries not yet written since reset get zero weight. A stalled receiver
// holds the word in the output register while the next input is filtered.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_fir_smoother import mfs_pkg::*; #(
	parameter int TAPS     = DEF_TAPS,
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	mfs_in_if.sink                     din,
	mfs_out_if.source                  dout,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	mfs_cmd_t cmd;
	mfs_sts_t sts;

	mfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	mfs_datapath #(
		.TAPS     (TAPS),
		.CHANNELS (CHANNELS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.channel     (din.channel),
		.sample      (din.sample),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_ready   (dout.ready),
		.out_valid   (dout.valid),
		.out_channel (dout.out_channel),
		.filtered    (dout.filtered)
	);

endmodule

`default_nettype wire

@@ rtl/core/mfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// mfs_ctrl
// Sequencer: accepts one word, steps the datapath through the taps,
// drains the multiply pipeline and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mfs_ctrl import mfs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output mfs_cmd_t      cmd,
	input  wire mfs_sts_t sts
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_MAC    = 5'b00010,
		S_DRAIN1 = 5'b00100,
		S_DRAIN2 = 5'b01000,
		S_FIN    = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					// out-of-range channel skips the taps, result stays zero
					state_d = sts.ch_ok ? S_MAC : S_FIN;
				end
			end
			S_MAC: begin
				cmd.issue = 1'b1;
				if (sts.last_tap) begin
					state_d = S_DRAIN1;
				end
			end
			S_DRAIN1: begin
				state_d = S_DRAIN2;
			end
			S_DRAIN2: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/mfs_datapath.sv @@
// ----------------------------------------------------------------------------
// mfs_datapath
// History memory, per-channel pointers, coefficient registers, one shared
// multiply-accumulate with a two-stage pipe, saturation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mfs_datapath import mfs_pkg::*; #(
	parameter int TAPS     = DEF_TAPS,
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire mfs_cmd_t                   cmd,
	output mfs_sts_t                        sts,
	input  wire logic [CH_W-1:0]            channel,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                       out_ready,
	output logic                            out_valid,
	output logic [CH_W-1:0]                 out_channel,
	output logic signed [SAMPLE_W-1:0]      filtered
);

	localparam int TP_W     = $clog2(TAPS);
	localparam int FILL_W   = $clog2(TAPS + 1);
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DEPTH    = CHANNELS * TAPS;
	localparam int ADDR_W   = $clog2(DEPTH);

	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

	// Storage
	logic signed [SAMPLE_W-1:0] hist_mem [DEPTH];
	logic [TP_W-1:0]            pos_q    [CHANNELS];
	logic [FILL_W-1:0]          fill_q   [CHANNELS];
	logic signed [COEF_W-1:0]   coef_q   [NUM_COEFS];

	// Per-word working registers
	logic [CH_W-1:0]   ch_q;
	logic [ADDR_W-1:0] base_q;
	logic [TP_W-1:0]   rd_q;
	logic [TP_W-1:0]   tap_q;
	logic [FILL_W-1:0] fill_cur_q;

	// MAC pipe
	logic signed [SAMPLE_W-1:0] rdata_s1;
	logic [TP_W-1:0]            tap_s1;
	logic                       vld_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	logic                       vld_s2;
	logic signed [ACC_W-1:0]    acc_q;

	// Output register
	logic                       out_valid_q;
	logic [CH_W-1:0]            out_ch_q;
	logic signed [SAMPLE_W-1:0] out_filt_q;

	logic                       ch_ok;
	logic [CH_IDX_W-1:0]        ch_idx;
	logic [TP_W-1:0]            pos_cur;
	logic [TP_W-1:0]            pos_next;
	logic [FILL_W-1:0]          fill_next;
	logic [ADDR_W-1:0]          base_d;
	logic [ADDR_W-1:0]          wr_addr;
	logic [ADDR_W-1:0]          rd_addr;
	logic                       tap_live;
	logic signed [COEF_W-1:0]   weight;
	logic signed [ACC_W-1:0]    acc_shr;
	logic signed [SAMPLE_W-1:0] sat_val;

	// Channel decode and pointer updates
	assign ch_ok     = 32'(channel) < CHANNELS;
	assign ch_idx    = ch_ok ? CH_IDX_W'(channel) : '0;
	assign pos_cur   = pos_q[ch_idx];
	assign pos_next  = (pos_cur == TP_W'(TAPS - 1)) ? '0 : pos_cur + 1'b1;
	assign fill_next = (fill_q[ch_idx] == FILL_W'(TAPS)) ? fill_q[ch_idx]
		: fill_q[ch_idx] + 1'b1;
	assign base_d    = ADDR_W'(ch_idx) * ADDR_W'(TAPS);
	assign wr_addr   = base_d + ADDR_W'(pos_cur);
	assign rd_addr   = base_q + ADDR_W'(rd_q);

	assign sts.ch_ok    = ch_ok;
	assign sts.last_tap = (tap_q == TP_W'(TAPS - 1));
	assign sts.out_free = !out_valid_q || out_ready;

	// Pointer and fill state per channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pos_q[i]  <= '0;
				fill_q[i] <= '0;
			end
		end else if (cmd.start && ch_ok) begin
			pos_q[ch_idx]  <= pos_next;
			fill_q[ch_idx] <= fill_next;
		end
	end

	// Coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we && (cfg_index <= REG_COEF_LAST)) begin
			coef_q[COEF_IDX_W'(cfg_index)] <= COEF_W'(cfg_data);
		end
	end

	// History memory: one write on accept, one registered read per tap
	always_ff @(posedge clk) begin
		if (cmd.start && ch_ok) begin
			hist_mem[wr_addr] <= sample;
		end
		if (cmd.issue) begin
			rdata_s1 <= hist_mem[rd_addr];
		end
	end

	// Word latch and tap walk, newest sample first
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ch_q       <= channel;
			base_q     <= base_d;
			rd_q       <= pos_cur;
			tap_q      <= '0;
			fill_cur_q <= fill_next;
		end else if (cmd.issue) begin
			rd_q   <= (rd_q == '0) ? TP_W'(TAPS - 1) : rd_q - 1'b1;
			tap_q  <= tap_q + 1'b1;
			tap_s1 <= tap_q;
		end
	end

	// A tap counts only if it has a coefficient and has been written
	assign tap_live = (32'(tap_s1) < NUM_COEFS) && (FILL_W'(tap_s1) < fill_cur_q);
	assign weight   = tap_live ? coef_q[COEF_IDX_W'(tap_s1)] : '0;

	// Multiply stage
	always_ff @(posedge clk) begin
		prod_s2 <= weight * rdata_s1;
	end

	// Pipe valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	// Accumulate
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Scale back by the fraction bits (floor) and saturate
	assign acc_shr = acc_q >>> FRAC_BITS;
	always_comb begin
		priority if (acc_shr > SAT_MAX) begin
			sat_val = SAMPLE_W'(SAT_MAX);
		end else if (acc_shr < SAT_MIN) begin
			sat_val = SAMPLE_W'(SAT_MIN);
		end else begin
			sat_val = SAMPLE_W'(acc_shr);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_ch_q   <= ch_q;
			out_filt_q <= sat_val;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_ch_q;
	assign filtered    = out_filt_q;

endmodule

`default_nettype wire

@@ rtl/core/mfs_checker.sv @@
// ----------------------------------------------------------------------------
// mfs_checker
// Port-level checks for the smoother, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multichannel_fir_smoother_defines.svh"

module mfs_checker import mfs_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [CH_W-1:0]            out_channel,
	input wire logic signed [SAMPLE_W-1:0] filtered
);

	logic in_acc;
	logic out_stall;

	assign in_acc    = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;

	// A stalled output word holds
	`MFS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_channel) && $stable(filtered), "output word changed while stalled")

	// One word at a time: no new input right after one is taken
	`MFS_ASSERT_NEXT(a_one_in_flight, in_acc, !in_ready, "input taken while a word is in work")

	// No result can appear in the cycle right after an accept
	`MFS_ASSERT_NEXT(a_min_latency, in_acc, !$rose(out_valid), "result appeared too early")

	// Out-of-range channels filter to zero
	`MFS_ASSERT_IMPL(a_bad_ch_zero, out_valid && (32'(out_channel) >= CHANNELS), filtered == '0, "nonzero result for unknown channel")

endmodule

bind multichannel_fir_smoother mfs_checker #(
	.CHANNELS (CHANNELS)
) u_mfs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (din.valid),
	.in_ready    (din.ready),
	.out_valid   (dout.valid),
	.out_ready   (dout.ready),
	.out_channel (dout.out_channel),
	.filtered    (dout.filtered)
);

`default_nettype wire
